// ===== sv/jsu_pkg.sv =====
// Shared types, character codes and helper functions for the JSON string unescaper.
// Used by the front, the job queue and the back of json_string_unescape_utf8.
package jsu_pkg;

	// Characters that open or name an escape.
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_U      = 8'h75;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_B      = 8'h62;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;

	// Control characters produced by the short escapes.
	localparam logic [7:0] CTL_BS  = 8'h08;
	localparam logic [7:0] CTL_FF  = 8'h0C;
	localparam logic [7:0] CTL_LF  = 8'h0A;
	localparam logic [7:0] CTL_CR  = 8'h0D;
	localparam logic [7:0] CTL_TAB = 8'h09;

	// Surrogate ranges and the base of the supplementary planes.
	localparam logic [15:0] HI_FIRST  = 16'hD800;
	localparam logic [15:0] HI_LAST   = 16'hDBFF;
	localparam logic [15:0] LO_FIRST  = 16'hDC00;
	localparam logic [15:0] LO_LAST   = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE = 21'h10000;

	// UTF-8 length limits, lead bytes and continuation marks.
	localparam logic [20:0] UTF8_LIM1 = 21'h80;
	localparam logic [20:0] UTF8_LIM2 = 21'h800;
	localparam logic [20:0] UTF8_LIM3 = 21'h10000;
	localparam logic [7:0]  LEAD2     = 8'hC0;
	localparam logic [7:0]  LEAD3     = 8'hE0;
	localparam logic [7:0]  LEAD4     = 8'hF0;
	localparam logic [7:0]  CONT      = 8'h80;

	// Sizes of a job and of the queue between front and back.
	localparam int LIT_MAX = 5;
	localparam int VEC_MAX = 8;
	localparam int Q_DEPTH = 4;

	// One job: an optional high surrogate, an optional code point, then literal bytes.
	typedef struct packed {
		logic                      hi_en;
		logic [15:0]               hi;
		logic                      cp_en;
		logic [20:0]               cp;
		logic [2:0]                lit_n;
		logic [LIT_MAX-1:0][7:0]   lit;
	} jsu_job_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] ch;
	} jsu_esc_t;

	typedef struct packed {
		logic [2:0]      len;
		logic [3:0][7:0] b;
	} jsu_utf8_t;

	// Value of one hex digit; anything that is not a hex digit counts as zero.
	function automatic logic [3:0] hex_val(input logic [7:0] h);
		logic [3:0] v;
		v = 4'd0;
		if (h inside {[8'h30:8'h39]}) begin
			v = h[3:0];
		end else if (h inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			v = 4'(h[3:0] + 4'd9);
		end
		return v;
	endfunction

	// Result of a two-character escape whose second character is c.
	function automatic jsu_esc_t esc_map(input logic [7:0] c);
		jsu_esc_t r;
		r.hit = 1'b1;
		r.ch  = c;
		case (c)
			CH_QUOTE:  r.ch = CH_QUOTE;
			CH_BSLASH: r.ch = CH_BSLASH;
			CH_SLASH:  r.ch = CH_SLASH;
			CH_B:      r.ch = CTL_BS;
			CH_F:      r.ch = CTL_FF;
			CH_N:      r.ch = CTL_LF;
			CH_R:      r.ch = CTL_CR;
			CH_T:      r.ch = CTL_TAB;
			default:   r.hit = 1'b0;
		endcase
		return r;
	endfunction

	// UTF-8 encoding of a code point, lead byte in b[0].
	function automatic jsu_utf8_t utf8_enc(input logic [20:0] cp);
		jsu_utf8_t r;
		r = '0;
		if (cp < UTF8_LIM1) begin
			r.len  = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < UTF8_LIM2) begin
			r.len  = 3'd2;
			r.b[0] = LEAD2 | {3'b000, cp[10:6]};
			r.b[1] = CONT | {2'b00, cp[5:0]};
		end else if (cp < UTF8_LIM3) begin
			r.len  = 3'd3;
			r.b[0] = LEAD3 | {4'b0000, cp[15:12]};
			r.b[1] = CONT | {2'b00, cp[11:6]};
			r.b[2] = CONT | {2'b00, cp[5:0]};
		end else begin
			r.len  = 3'd4;
			r.b[0] = LEAD4 | {5'b00000, cp[20:18]};
			r.b[1] = CONT | {2'b00, cp[17:12]};
			r.b[2] = CONT | {2'b00, cp[11:6]};
			r.b[3] = CONT | {2'b00, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== sv/jsu_front.sv =====
// Front of the unescaper: takes one input byte per cycle when q_ready, tracks the open
// escape and hands a job describing the bytes to emit to the queue. Depends on jsu_pkg.
module jsu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [7:0]       in_byte,
	input  logic             in_last,
	input  logic             q_ready,
	output logic             push,
	output jsu_pkg::jsu_job_t job
);
	import jsu_pkg::*;

	// Parse states; each code equals the number of bytes still held.
	localparam logic [3:0] P_IDLE    = 4'd0;
	localparam logic [3:0] P_BS      = 4'd1;
	localparam logic [3:0] P_U0      = 4'd2;
	localparam logic [3:0] P_U1      = 4'd3;
	localparam logic [3:0] P_U2      = 4'd4;
	localparam logic [3:0] P_U3      = 4'd5;
	localparam logic [3:0] P_HI      = 4'd6;
	localparam logic [3:0] P_HI_BS   = 4'd7;
	localparam logic [3:0] P_HI_U0   = 4'd8;
	localparam logic [3:0] P_HI_U1   = 4'd9;
	localparam logic [3:0] P_HI_U2   = 4'd10;
	localparam logic [3:0] P_HI_U3   = 4'd11;

	typedef struct packed {
		logic [2:0]      n;
		logic [2:0][7:0] b;
	} short_t;

	logic [3:0]      state_q;
	logic [3:0]      state_d;
	logic [2:0][7:0] raw_q;
	logic [15:0]     hi_q;
	logic [15:0]     hi_d;
	logic            hi_we;
	logic            raw_we;
	logic [1:0]      grp_k;
	logic            acc;
	logic [15:0]     quad;
	logic [20:0]     pair_cp;
	jsu_esc_t        ec;
	jsu_job_t        job_d;
	logic [2:0][7:0] sseq;
	short_t          sdec;

	// Decode a cut-short tail of at most three bytes: only two-character escapes apply.
	function automatic short_t short_dec(input logic [2:0][7:0] s, input logic [1:0] len);
		short_t   r;
		jsu_esc_t e0;
		jsu_esc_t e1;
		r  = '0;
		e0 = esc_map(s[1]);
		e1 = esc_map(s[2]);
		if (s[0] == CH_BSLASH && len >= 2'd2 && e0.hit) begin
			r.b[0] = e0.ch;
			r.n    = 3'd1;
			if (len == 2'd3) begin
				r.b[1] = s[2];
				r.n    = 3'd2;
			end
		end else begin
			r.b[0] = s[0];
			r.n    = 3'd1;
			if (len == 2'd3 && s[1] == CH_BSLASH && e1.hit) begin
				r.b[1] = e1.ch;
				r.n    = 3'd2;
			end else begin
				if (len >= 2'd2) begin
					r.b[1] = s[1];
					r.n    = 3'd2;
				end
				if (len == 2'd3) begin
					r.b[2] = s[2];
					r.n    = 3'd3;
				end
			end
		end
		return r;
	endfunction

	assign in_ready = q_ready;
	assign acc      = in_valid && q_ready;

	// Position within the four hex digits for both the first and the second escape.
	always_comb begin
		case (state_q)
			P_U0, P_HI_U0: grp_k = 2'd0;
			P_U1, P_HI_U1: grp_k = 2'd1;
			P_U2, P_HI_U2: grp_k = 2'd2;
			default:       grp_k = 2'd0;
		endcase
	end

	// Tail that follows a backslash and u when the string ends inside the hex digits.
	always_comb begin
		sseq = '0;
		case (grp_k)
			2'd0: sseq[0] = in_byte;
			2'd1: begin
				sseq[0] = raw_q[0];
				sseq[1] = in_byte;
			end
			default: begin
				sseq[0] = raw_q[0];
				sseq[1] = raw_q[1];
				sseq[2] = in_byte;
			end
		endcase
		sdec = short_dec(sseq, 2'(grp_k + 2'd1));
	end

	assign quad    = {hex_val(raw_q[0]), hex_val(raw_q[1]), hex_val(raw_q[2]), hex_val(in_byte)};
	assign pair_cp = SUPP_BASE + {1'b0, hi_q[9:0], quad[9:0]};
	assign ec      = esc_map(in_byte);

	// Classify the byte against the open escape and build the job.
	always_comb begin
		job_d   = '0;
		state_d = state_q;
		hi_we   = 1'b0;
		hi_d    = quad;
		raw_we  = 1'b0;
		job_d.hi = hi_q;
		case (state_q)
			P_IDLE: begin
				if (in_byte == CH_BSLASH && !in_last) begin
					state_d = P_BS;
				end else begin
					job_d.lit[0] = in_byte;
					job_d.lit_n  = 3'd1;
				end
			end
			P_BS: begin
				state_d = P_IDLE;
				if (ec.hit) begin
					job_d.lit[0] = ec.ch;
					job_d.lit_n  = 3'd1;
				end else if (in_byte == CH_U && !in_last) begin
					state_d = P_U0;
				end else begin
					job_d.lit[0] = CH_BSLASH;
					job_d.lit[1] = in_byte;
					job_d.lit_n  = 3'd2;
				end
			end
			P_U0, P_U1, P_U2, P_HI_U0, P_HI_U1, P_HI_U2: begin
				if (!in_last) begin
					raw_we  = 1'b1;
					state_d = 4'(state_q + 4'd1);
				end else begin
					// String ends inside the hex digits: the escape passes through literally.
					state_d      = P_IDLE;
					job_d.hi_en  = (state_q >= P_HI_U0);
					job_d.lit[0] = CH_BSLASH;
					job_d.lit[1] = CH_U;
					job_d.lit[2] = sdec.b[0];
					job_d.lit[3] = sdec.b[1];
					job_d.lit[4] = sdec.b[2];
					job_d.lit_n  = 3'(sdec.n + 3'd2);
				end
			end
			P_U3: begin
				if (quad >= HI_FIRST && quad <= HI_LAST && !in_last) begin
					hi_we   = 1'b1;
					state_d = P_HI;
				end else begin
					state_d     = P_IDLE;
					job_d.cp_en = 1'b1;
					job_d.cp    = {5'b00000, quad};
				end
			end
			P_HI: begin
				if (in_byte == CH_BSLASH && !in_last) begin
					state_d = P_HI_BS;
				end else begin
					state_d      = P_IDLE;
					job_d.hi_en  = 1'b1;
					job_d.lit[0] = in_byte;
					job_d.lit_n  = 3'd1;
				end
			end
			P_HI_BS: begin
				if (in_byte == CH_U && !in_last) begin
					state_d = P_HI_U0;
				end else begin
					state_d     = P_IDLE;
					job_d.hi_en = 1'b1;
					if (ec.hit) begin
						job_d.lit[0] = ec.ch;
						job_d.lit_n  = 3'd1;
					end else begin
						job_d.lit[0] = CH_BSLASH;
						job_d.lit[1] = in_byte;
						job_d.lit_n  = 3'd2;
					end
				end
			end
			P_HI_U3: begin
				state_d = P_IDLE;
				if (quad >= LO_FIRST && quad <= LO_LAST) begin
					// A valid surrogate pair joins into one code point.
					job_d.cp_en = 1'b1;
					job_d.cp    = pair_cp;
				end else begin
					job_d.hi_en = 1'b1;
					if (quad >= HI_FIRST && quad <= HI_LAST && !in_last) begin
						hi_we   = 1'b1;
						state_d = P_HI;
					end else begin
						job_d.cp_en = 1'b1;
						job_d.cp    = {5'b00000, quad};
					end
				end
			end
			default: state_d = P_IDLE;
		endcase
	end

	assign job  = job_d;
	assign push = acc && (job_d.hi_en || job_d.cp_en || job_d.lit_n != 3'd0);

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= P_IDLE;
		end else if (acc) begin
			state_q <= state_d;
		end
	end

	// Held hex digits and high surrogate.
	always_ff @(posedge clk) begin
		if (acc && raw_we) begin
			raw_q[grp_k] <= in_byte;
		end
		if (acc && hi_we) begin
			hi_q <= hi_d;
		end
	end

endmodule

// ===== sv/jsu_queue.sv =====
// Short job queue between the front and the back of the unescaper.
// Register storage of jsu_pkg::Q_DEPTH jobs; depends on jsu_pkg.
module jsu_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  jsu_pkg::jsu_job_t din,
	output logic              ready,
	input  logic              pop,
	output logic              valid,
	output jsu_pkg::jsu_job_t dout
);
	import jsu_pkg::*;

	localparam int AW = $clog2(Q_DEPTH);
	localparam int CW = $clog2(Q_DEPTH + 1);

	jsu_job_t        mem_q [Q_DEPTH];
	logic [AW-1:0]   wr_q;
	logic [AW-1:0]   rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign ready   = (cnt_q != CW'(Q_DEPTH));
	assign valid   = (cnt_q != '0);
	assign do_push = push && ready;
	assign do_pop  = pop && valid;
	assign dout    = mem_q[rd_q];

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= AW'(wr_q + 1'b1);
			end
			if (do_pop) begin
				rd_q <= AW'(rd_q + 1'b1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= CW'(cnt_q + 1'b1);
			end else if (do_pop && !do_push) begin
				cnt_q <= CW'(cnt_q - 1'b1);
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= din;
		end
	end

endmodule

// ===== sv/jsu_back.sv =====
// Back of the unescaper: expands a job into UTF-8 and literal bytes and shifts them
// out one transaction per cycle while out_ready is high, tlast on each job's final byte. Depends on jsu_pkg.
module jsu_back (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	input  jsu_pkg::jsu_job_t job,
	output logic              job_pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [7:0]        out_byte,
	output logic              out_last
);
	import jsu_pkg::*;

	logic [VEC_MAX-1:0][7:0] vec_q;
	logic [VEC_MAX-1:0][7:0] vec_d;
	logic [3:0]              cnt_q;
	logic [3:0]              tot;
	logic [3:0]              o1;
	logic [3:0]              o2;
	logic [3:0]              kk;
	logic [3:0]              ci;
	logic [3:0]              li;
	logic                    take;
	logic                    load;
	jsu_utf8_t               hb;
	jsu_utf8_t               cb;

	assign out_valid = (cnt_q != 4'd0);
	assign out_byte  = vec_q[0];
	assign out_last  = (cnt_q == 4'd1);
	assign take      = out_valid && out_ready;
	assign load      = job_valid && (cnt_q == 4'd0 || (cnt_q == 4'd1 && take));
	assign job_pop   = load;

	// Lay out high surrogate, code point and literals back to back.
	always_comb begin
		hb = utf8_enc({5'b00000, job.hi});
		cb = utf8_enc(job.cp);
		o1 = job.hi_en ? 4'd3 : 4'd0;
		o2 = 4'(o1 + (job.cp_en ? {1'b0, cb.len} : 4'd0));
		tot = 4'(o2 + {1'b0, job.lit_n});
		kk = 4'd0;
		ci = 4'd0;
		li = 4'd0;
		for (int k = 0; k < VEC_MAX; k++) begin
			kk = 4'(k);
			ci = 4'(kk - o1);
			li = 4'(kk - o2);
			if (kk < o1) begin
				vec_d[k] = hb.b[kk[1:0]];
			end else if (kk < o2) begin
				vec_d[k] = cb.b[ci[1:0]];
			end else if (li < 4'(LIT_MAX)) begin
				vec_d[k] = job.lit[li[2:0]];
			end else begin
				vec_d[k] = 8'h00;
			end
		end
	end

	// Byte count of the job in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 4'd0;
		end else if (load) begin
			cnt_q <= tot;
		end else if (take) begin
			cnt_q <= 4'(cnt_q - 4'd1);
		end
	end

	// Output shift register.
	always_ff @(posedge clk) begin
		if (load) begin
			vec_q <= vec_d;
		end else if (take) begin
			vec_q <= {8'h00, vec_q[VEC_MAX-1:1]};
		end
	end

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// Path: the job of an accepted input byte is written into the job queue and then loaded
// into the output shift register, from which its first output byte is presented.
// Throughput: one input byte per cycle while the four-entry job queue has room; the output
// side moves one byte per cycle while m_axis_tready is high; a job holds the back until all its bytes leave.
// Reset: arst_n clears the escape parser state, the job queue pointers and the output byte count at once.
// Depends on jsu_pkg, jsu_front, jsu_queue and jsu_back.
module json_string_unescape_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
	input  logic       s_axis_tlast,   // in_last
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,   // [7:0] out_byte
	output logic       m_axis_tlast    // out_last
);
	import jsu_pkg::*;

	logic     push;
	logic     q_ready;
	logic     q_valid;
	logic     pop;
	jsu_job_t job_in;
	jsu_job_t job_out;

	// Escape parser.
	jsu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_byte  (s_axis_tdata),
		.in_last  (s_axis_tlast),
		.q_ready  (q_ready),
		.push     (push),
		.job      (job_in)
	);

	// Jobs waiting for the output side.
	jsu_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (job_in),
		.ready  (q_ready),
		.pop    (pop),
		.valid  (q_valid),
		.dout   (job_out)
	);

	// UTF-8 expansion and output stream.
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_valid),
		.job       (job_out),
		.job_pop   (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast)
	);

endmodule

// ===== test/json_string_unescape_utf8_test.sv =====
// Self-checking testbench for json_string_unescape_utf8: random and directed JSON string bodies
// go in as byte transactions, and a behavioral decoder predicts every UTF-8 output byte.
// Depends on jsu_pkg for the character codes and on the RTL of the block.
module json_string_unescape_utf8_test;
	import jsu_pkg::*;

	// One input byte with its end-of-string flag; hold makes the sender wait for a drained output.
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       hold;
	} in_byte_t;

	// One expected output transaction.
	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} out_byte_t;

	// Second characters of the eight short escapes.
	localparam logic [7:0][7:0] SHORT_ESC = {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B,
		CH_F, CH_N, CH_R, CH_T};
	// Idling stops once no more input bytes than this are left.
	localparam int CALM_TAIL = 30;
	localparam int STIM_BYTES = 300;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_axis_tvalid = 1'b0;
	logic       s_axis_tready;
	logic [7:0] s_axis_tdata = 8'h00;   // [7:0] in_byte
	logic       s_axis_tlast = 1'b0;    // in_last
	logic       m_axis_tvalid;
	logic       m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;           // [7:0] out_byte
	logic       m_axis_tlast;           // out_last

	in_byte_t   byte_feed[$];
	out_byte_t  utf8_due[$];
	logic [7:0] text[$];
	in_byte_t   next_in;
	out_byte_t  due_head;
	bit         drain_next = 1'b0;
	bit         in_fire = 1'b0;
	int         send_gap = 0;
	int         take_gap = 0;
	int         errors = 0;

	// Decoder state: bytes whose meaning is not settled yet.
	logic [7:0] held [0:10];
	int         held_n = 0;
	logic [7:0] scan [0:11];

	json_string_unescape_utf8 u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #4 clk = ~clk;

	// Hex digit value; any other byte reads as zero.
	function automatic logic [3:0] nibble_of(input logic [7:0] h);
		if (h >= "0" && h <= "9") return 4'(h - "0");
		if (h >= "a" && h <= "f") return 4'(h - "a" + 10);
		if (h >= "A" && h <= "F") return 4'(h - "A" + 10);
		return 4'd0;
	endfunction

	function automatic logic [15:0] quad_at(input int p);
		logic [15:0] v;
		int k;
		v = '0;
		for (k = 0; k < 4; k++) v = {v[11:0], nibble_of(scan[p + k])};
		return v;
	endfunction

	// UTF-8 bytes of a code point, lead byte first; returns the byte count.
	function automatic int encode_utf8(input logic [20:0] cp, output logic [3:0][7:0] o);
		o = '0;
		if (cp < 21'h80) begin
			o[0] = cp[7:0];
			return 1;
		end
		if (cp < 21'h800) begin
			o[0] = 8'hC0 | {3'b000, cp[10:6]};
			o[1] = 8'h80 | {2'b00, cp[5:0]};
			return 2;
		end
		if (cp < 21'h10000) begin
			o[0] = 8'hE0 | {4'b0000, cp[15:12]};
			o[1] = 8'h80 | {2'b00, cp[11:6]};
			o[2] = 8'h80 | {2'b00, cp[5:0]};
			return 3;
		end
		o[0] = 8'hF0 | {5'b00000, cp[20:18]};
		o[1] = 8'h80 | {2'b00, cp[17:12]};
		o[2] = 8'h80 | {2'b00, cp[11:6]};
		o[3] = 8'h80 | {2'b00, cp[5:0]};
		return 4;
	endfunction

	// Settles the token at scan[p], with n bytes in scan; returns -1 when it needs more input.
	function automatic int settle_token(input int p, input int n, input bit fin,
			output logic [3:0][7:0] o, output int used);
		logic [7:0]  c;
		logic [20:0] cp;
		logic [15:0] lo;
		bit          pair_ok;
		int          m;
		o = '0;
		used = 1;
		m = n - p;
		if (scan[p] != CH_BSLASH) begin
			o[0] = scan[p];
			return 1;
		end
		if (m < 2) begin
			if (!fin) return -1;
			o[0] = CH_BSLASH;
			return 1;
		end
		c = scan[p + 1];
		used = 2;
		case (c)
			CH_QUOTE, CH_BSLASH, CH_SLASH: o[0] = c;
			CH_B: o[0] = CTL_BS;
			CH_F: o[0] = CTL_FF;
			CH_N: o[0] = CTL_LF;
			CH_R: o[0] = CTL_CR;
			CH_T: o[0] = CTL_TAB;
			default: used = 1;
		endcase
		if (used == 2) return 1;
		// An unknown escape or a cut-short \u lets the backslash through on its own.
		if (c != CH_U) begin
			o[0] = CH_BSLASH;
			return 1;
		end
		if (m < 6) begin
			if (!fin) return -1;
			o[0] = CH_BSLASH;
			return 1;
		end
		cp = {5'd0, quad_at(p + 2)};
		used = 6;
		// A high surrogate joins a directly following low surrogate escape.
		if (cp >= HI_FIRST && cp <= HI_LAST) begin
			pair_ok = 1'b1;
			if (m >= 7 && scan[p + 6] != CH_BSLASH) pair_ok = 1'b0;
			if (pair_ok && m >= 8 && scan[p + 7] != CH_U) pair_ok = 1'b0;
			if (pair_ok && m < 12) begin
				if (!fin) return -1;
				pair_ok = 1'b0;
			end
			if (pair_ok) begin
				lo = quad_at(p + 8);
				if (lo >= LO_FIRST && lo <= LO_LAST) begin
					cp = SUPP_BASE + {cp[9:0], lo[9:0]};
					used = 12;
				end
			end
		end
		return encode_utf8(cp, o);
	endfunction

	// Feeds one accepted byte to the decoder and queues the output bytes it releases.
	task automatic predict_unescape(input logic [7:0] b, input logic fin);
		logic [3:0][7:0] o;
		logic [7:0]      res[$];
		out_byte_t       ob;
		int              n, p, r, used, k;
		n = held_n;
		for (k = 0; k < n; k++) scan[k] = held[k];
		scan[n] = b;
		n++;
		p = 0;
		while (p < n) begin
			r = settle_token(p, n, fin, o, used);
			if (r < 0) break;
			for (k = 0; k < r; k++) res = {res, o[k]};
			p += used;
		end
		held_n = n - p;
		for (k = 0; k < held_n; k++) held[k] = scan[p + k];
		for (k = 0; k < res.size(); k++) begin
			ob.code = res[k];
			ob.last = (k == res.size() - 1);
			utf8_due = {utf8_due, ob};
		end
	endtask

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 10) return 8'("0" + v);
		return 8'(($urandom_range(0, 1) ? "a" : "A") + v - 10);
	endfunction

	// Appends one byte to the text buffer.
	task automatic add_char(input logic [7:0] ch);
		text = {text, ch};
	endtask

	// Appends \uXXXX; with noise, a digit is now and then replaced by an arbitrary byte.
	task automatic add_quad(input logic [15:0] v, input bit noise);
		int k;
		add_char(CH_BSLASH);
		add_char(CH_U);
		for (k = 3; k >= 0; k--) begin
			if (noise && $urandom_range(0, 15) == 0) add_char(8'($urandom_range(0, 255)));
			else add_char(hex_char(v[k*4 +: 4]));
		end
	endtask

	// Turns the text buffer into one string of input bytes, flagged on its final byte.
	task automatic emit_text();
		in_byte_t nb;
		int k;
		for (k = 0; k < text.size(); k++) begin
			nb.data = text[k];
			nb.last = (k == text.size() - 1);
			nb.hold = (k == 0 && drain_next);
			byte_feed = {byte_feed, nb};
		end
		drain_next = 1'b0;
		text.delete();
	endtask

	task automatic add_token();
		case ($urandom_range(0, 9))
			0, 1, 2: add_char(8'($urandom_range(32, 126)));
			3: add_char(8'($urandom_range(0, 255)));
			4: begin
				add_char(CH_BSLASH);
				add_char(SHORT_ESC[$urandom_range(0, 7)]);
			end
			5: begin
				add_char(CH_BSLASH);
				add_char(8'($urandom_range(0, 255)));
			end
			6: add_quad(16'($urandom), 1'b1);
			7: begin
				add_quad({6'b110110, 10'($urandom)}, 1'b1);
				add_quad({6'b110111, 10'($urandom)}, 1'b1);
			end
			8: begin
				// High surrogate followed by something other than a low surrogate escape.
				add_quad({6'b110110, 10'($urandom)}, 1'b1);
				case ($urandom_range(0, 3))
					0: add_char(8'($urandom_range(32, 126)));
					1: begin
						add_char(CH_BSLASH);
						add_char(SHORT_ESC[$urandom_range(0, 7)]);
					end
					2: add_quad({2'b00, 14'($urandom)}, 1'b1);
					default: ;
				endcase
			end
			default: add_quad({5'b11011, 11'($urandom)}, 1'b1);
		endcase
	endtask

	task automatic add_random_string();
		int cut;
		repeat ($urandom_range(1, 6)) add_token();
		// Now and then the string loses up to five final bytes and may end inside an escape.
		if ($urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, 5);
			while (cut > 0 && text.size() > 1) begin
				text.delete(text.size() - 1);
				cut--;
			end
		end
		emit_text();
	endtask

	// Sender: presents the next byte at the falling edge, with random idle bursts.
	always @(negedge clk) begin
		if (arst_n && (!s_axis_tvalid || in_fire)) begin
			if (send_gap > 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap--;
			end else if (byte_feed.size() == 0 ||
					(byte_feed[0].hold && utf8_due.size() != 0)) begin
				s_axis_tvalid <= 1'b0;
			end else if (byte_feed.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
				s_axis_tvalid <= 1'b0;
				send_gap = $urandom_range(0, 3);
			end else begin
				next_in = byte_feed.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= next_in.data;
				s_axis_tlast  <= next_in.last;
			end
		end
	end

	// Receiver: random stall bursts on tready until the tail of the run.
	always @(negedge clk) begin
		if (take_gap > 0) begin
			m_axis_tready <= 1'b0;
			take_gap--;
		end else if (byte_feed.size() > CALM_TAIL && $urandom_range(0, 5) == 0) begin
			m_axis_tready <= 1'b0;
			take_gap = $urandom_range(0, 3);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Monitor: predicts on each input transaction and checks each output transaction.
	always @(posedge clk) begin
		in_fire <= arst_n && s_axis_tvalid && s_axis_tready;
		if (arst_n && s_axis_tvalid && s_axis_tready) predict_unescape(s_axis_tdata, s_axis_tlast);
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (utf8_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected output byte %02h last %b", $time, m_axis_tdata,
					m_axis_tlast);
			end else begin
				due_head = utf8_due.pop_front();
				if (m_axis_tdata !== due_head.code) begin
					errors++;
					$display("%0t: out_byte expected %02h actual %02h", $time, due_head.code,
						m_axis_tdata);
				end
				if (m_axis_tlast !== due_head.last) begin
					errors++;
					$display("%0t: out_last expected %b actual %b", $time, due_head.last,
						m_axis_tlast);
				end
			end
		end
	end

	// Stimulus, reset and end of run.
	initial begin
		// Extreme byte values as plain text.
		add_char(8'h00);
		add_char(8'hFF);
		emit_text();
		// Surrogate pair that fills the pending store and yields four bytes.
		add_quad(16'hD83D, 1'b0);
		add_quad(16'hDE00, 1'b0);
		emit_text();
		// Lone low surrogate with a non-hex digit, then a trailing backslash.
		add_char(CH_BSLASH);
		add_char(CH_U);
		add_char(hex_char(4'hD));
		add_char(hex_char(4'hC));
		add_char(hex_char(4'h0));
		add_char(8'h47);
		add_char(CH_BSLASH);
		emit_text();
		// A \u escape cut short by the end of the string.
		add_char(CH_BSLASH);
		add_char(CH_U);
		add_char(hex_char(4'h1));
		add_char(hex_char(4'h2));
		emit_text();
		drain_next = 1'b1;
		while (byte_feed.size() < STIM_BYTES) begin
			if (byte_feed.size() > STIM_BYTES / 2 && byte_feed.size() < STIM_BYTES / 2 + 8)
				drain_next = 1'b1;
			add_random_string();
		end

		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		while (byte_feed.size() != 0 || s_axis_tvalid || utf8_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#2000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
